// File: sv/collider_pair_overlap_test_defines.svh
// ----------------------------------------------------------------------------
// Collider pair overlap test - assertion macros
// Shared concurrent assertion shorthands, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef COLLIDER_PAIR_OVERLAP_TEST_DEFINES_SVH
`define COLLIDER_PAIR_OVERLAP_TEST_DEFINES_SVH

// Same-cycle implication.
`define CPOT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cpot assertion failed");

// Next-cycle implication.
`define CPOT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cpot assertion failed");

`endif

// File: sv/cpot_pkg.sv
// ----------------------------------------------------------------------------
// Collider pair overlap test - package
// Action codes, pipeline depth and the control word that rides along.
// ----------------------------------------------------------------------------
package cpot_pkg;

  localparam logic [1:0] ACT_SPHERE = 2'd0;
  localparam logic [1:0] ACT_LINE   = 2'd1;

  // pipeline depth and the stages where control flags get filled in
  localparam int unsigned LAT        = 7;
  localparam int unsigned FLAG_STAGE = 3;
  localparam int unsigned LHS_STAGE  = 5;

  typedef struct packed {
    logic vld;
    logic is_ss;
    logic is_ls;
    logic ss_hit;
    logic dd_nz;
  } ctl_t;

endpackage

// File: sv/cpot_split_mul.sv
// ----------------------------------------------------------------------------
// Split signed multiplier
// Two-stage wide multiply: four half-width partial products are registered,
// then shifted and summed into the registered full product.
// ----------------------------------------------------------------------------
module cpot_split_mul #(
  parameter int AW = 51,
  parameter int BW = 51
) (
  input  logic                     clk_i,
  input  logic signed [AW-1:0]     a_i,
  input  logic signed [BW-1:0]     b_i,
  output logic signed [AW+BW-1:0]  p_o
);
  import cpot_pkg::*;

  localparam int LA = AW / 2;
  localparam int HA = AW - LA;
  localparam int LB = BW / 2;
  localparam int HB = BW - LB;
  localparam int PW = AW + BW;

  logic        [LA-1:0]       al;
  logic signed [HA-1:0]       ah;
  logic        [LB-1:0]       bl;
  logic signed [HB-1:0]       bh;

  logic        [LA+LB-1:0]    pll_d, pll_q;
  logic signed [LA+HB:0]      plh_d, plh_q;
  logic signed [HA+LB:0]      phl_d, phl_q;
  logic signed [HA+HB-1:0]    phh_d, phh_q;

  logic signed [PW-1:0]       t0, t1, t2, t3;
  logic signed [PW-1:0]       p_d, p_q;

  assign al = a_i[LA-1:0];
  assign ah = $signed(a_i[AW-1:LA]);
  assign bl = b_i[LB-1:0];
  assign bh = $signed(b_i[BW-1:LB]);

  // low halves are unsigned, high halves carry the sign
  assign pll_d = al * bl;
  assign plh_d = $signed({1'b0, al}) * bh;
  assign phl_d = ah * $signed({1'b0, bl});
  assign phh_d = ah * bh;

  assign t0 = $signed({{(PW-LA-LB){1'b0}}, pll_q});
  assign t1 = $signed({{(HA+LB-1){plh_q[LA+HB]}}, plh_q}) <<< LB;
  assign t2 = $signed({{(LA+HB-1){phl_q[HA+LB]}}, phl_q}) <<< LA;
  assign t3 = $signed({{(LA+LB){phh_q[HA+HB-1]}}, phh_q}) <<< (LA + LB);

  assign p_d = t0 + t1 + t2 + t3;

  always_ff @(posedge clk_i) begin
    pll_q <= pll_d;
    plh_q <= plh_d;
    phl_q <= phl_d;
    phh_q <= phh_d;
    p_q   <= p_d;
  end

  assign p_o = p_q;

endmodule

// File: sv/collider_pair_overlap_test.sv
// ----------------------------------------------------------------------------
// Collider pair overlap test
// Sphere-sphere and line-sphere overlap check on Q16.8 coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction enters when start_i is high and busy_o is low. busy_o is
//   always low: the pipeline takes one collider pair every cycle.
//   action_i selects sphere-sphere, line-sphere, or no test (no hit).
//   Each pair produces one result: done_o pulses for one cycle with hit_o.
//   The 7-stage datapath (subtract, products, cross/dot sums, two-stage split
//   multiply for the squared cross terms and R^2|d|^2, final sum, compare)
//   takes one pair per cycle.
//   Results leave in input order. The receiver cannot stall the block, so
//   results are never held back.
//   Reset clears all valid bits; pairs in flight are dropped and done_o
//   stays low until new transactions reach the output.
//   Sphere-sphere hits when |w|^2 < R^2; line-sphere hits when
//   |w x d|^2 <= R^2 |d|^2 with |d| nonzero.
// ----------------------------------------------------------------------------
`include "collider_pair_overlap_test_defines.svh"

module collider_pair_overlap_test #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    action_i,
  input  logic signed [COORD_BITS-1:0]  first_x_i,
  input  logic signed [COORD_BITS-1:0]  first_y_i,
  input  logic signed [COORD_BITS-1:0]  first_z_i,
  input  logic signed [COORD_BITS-1:0]  line_end_x_i,
  input  logic signed [COORD_BITS-1:0]  line_end_y_i,
  input  logic signed [COORD_BITS-1:0]  line_end_z_i,
  input  logic signed [COORD_BITS-1:0]  sphere_x_i,
  input  logic signed [COORD_BITS-1:0]  sphere_y_i,
  input  logic signed [COORD_BITS-1:0]  sphere_z_i,
  input  logic [COORD_BITS-2:0]         first_radius_i,
  input  logic [COORD_BITS-2:0]         sphere_radius_i,
  output logic                          done_o,
  output logic                          hit_o
);
  import cpot_pkg::*;

  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;        // difference vectors
  localparam int PW  = 2 * CW + 2;    // products of differences
  localparam int XW  = 2 * CW + 3;    // cross components
  localparam int SW  = 2 * CW + 3;    // dot sums
  localparam int R2W = 2 * CW;        // squared radius sum
  localparam int QW  = 2 * XW;        // squared cross component
  localparam int HW  = R2W + SW + 2;  // R^2 |d|^2
  localparam int LW  = 4 * CW + 8;    // compare width

  logic signed [CW-1:0] first_c [3];
  logic signed [CW-1:0] end_c   [3];
  logic signed [CW-1:0] ctr_c   [3];

  // S1
  logic signed [DW-1:0] w_d [3], w_q [3];
  logic signed [DW-1:0] d_d [3], d_q [3];
  logic [CW-1:0]        rsum_d, rsum_q;
  // S2
  logic signed [PW-1:0] pwd_d [6], pwd_q [6];
  logic signed [PW-1:0] sqd_d [3], sqd_q [3];
  logic signed [PW-1:0] sqw_d [3], sqw_q [3];
  logic [R2W-1:0]       r2s2_d, r2s2_q;
  // S3
  logic signed [XW-1:0] cross_d [3], cross_q [3];
  logic [SW-1:0]        dd_d, dd_q;
  logic [SW-1:0]        dist2_d, dist2_q;
  logic [R2W-1:0]       r2s3_q;
  // S4/S5 (inside the multipliers)
  logic signed [QW-1:0] csq [3];
  logic signed [HW-1:0] rhs;
  // S6
  logic [LW-1:0]        lhs_d, lhs_q;
  logic [LW-1:0]        rhs6_d, rhs6_q;
  // S7
  logic                 hit_d, hit_q;

  ctl_t ctl_d [LAT];
  ctl_t ctl_q [LAT];

  assign busy_o = 1'b0;

  assign first_c[0] = first_x_i;
  assign first_c[1] = first_y_i;
  assign first_c[2] = first_z_i;
  assign end_c[0]   = line_end_x_i;
  assign end_c[1]   = line_end_y_i;
  assign end_c[2]   = line_end_z_i;
  assign ctr_c[0]   = sphere_x_i;
  assign ctr_c[1]   = sphere_y_i;
  assign ctr_c[2]   = sphere_z_i;

  // ---- S1: difference vectors and radius sum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_d[i] = {ctr_c[i][CW-1], ctr_c[i]} - {first_c[i][CW-1], first_c[i]};
      d_d[i] = {end_c[i][CW-1], end_c[i]} - {first_c[i][CW-1], first_c[i]};
    end
    rsum_d = {1'b0, first_radius_i} + {1'b0, sphere_radius_i};
  end

  // ---- S2: products
  always_comb begin
    pwd_d[0] = w_q[1] * d_q[2];
    pwd_d[1] = w_q[2] * d_q[1];
    pwd_d[2] = w_q[2] * d_q[0];
    pwd_d[3] = w_q[0] * d_q[2];
    pwd_d[4] = w_q[0] * d_q[1];
    pwd_d[5] = w_q[1] * d_q[0];
    for (int i = 0; i < 3; i++) begin
      sqd_d[i] = d_q[i] * d_q[i];
      sqw_d[i] = w_q[i] * w_q[i];
    end
    r2s2_d = rsum_q * rsum_q;
  end

  // ---- S3: cross product and dot sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cross_d[i] = {pwd_q[2*i][PW-1], pwd_q[2*i]} - {pwd_q[2*i+1][PW-1], pwd_q[2*i+1]};
    end
    // squares are non-negative, so zero extension is exact
    dd_d    = {1'b0, sqd_q[0]} + {1'b0, sqd_q[1]} + {1'b0, sqd_q[2]};
    dist2_d = {1'b0, sqw_q[0]} + {1'b0, sqw_q[1]} + {1'b0, sqw_q[2]};
  end

  // ---- S4/S5: squared cross terms and R^2 |d|^2
  for (genvar k = 0; k < 3; k++) begin : g_csq
    cpot_split_mul #(
      .AW (XW),
      .BW (XW)
    ) u_csq (
      .clk_i (clk_i),
      .a_i   (cross_q[k]),
      .b_i   (cross_q[k]),
      .p_o   (csq[k])
    );
  end

  cpot_split_mul #(
    .AW (R2W + 1),
    .BW (SW + 1)
  ) u_rhs (
    .clk_i (clk_i),
    .a_i   ($signed({1'b0, r2s3_q})),
    .b_i   ($signed({1'b0, dd_q})),
    .p_o   (rhs)
  );

  // ---- S6: |w x d|^2
  assign lhs_d  = {2'b0, csq[0]} + {2'b0, csq[1]} + {2'b0, csq[2]};
  assign rhs6_d = {3'b0, rhs};

  // ---- S7: final decision
  always_comb begin
    hit_d = ctl_q[LHS_STAGE].vld &
            ((ctl_q[LHS_STAGE].is_ss & ctl_q[LHS_STAGE].ss_hit) |
             (ctl_q[LHS_STAGE].is_ls & ctl_q[LHS_STAGE].dd_nz & (lhs_q <= rhs6_q)));
  end

  // control word travels with the data
  always_comb begin
    ctl_d[0].vld    = start_i & ~busy_o;
    ctl_d[0].is_ss  = (action_i == ACT_SPHERE);
    ctl_d[0].is_ls  = (action_i == ACT_LINE);
    ctl_d[0].ss_hit = 1'b0;
    ctl_d[0].dd_nz  = 1'b0;
    for (int i = 1; i < LAT; i++) begin
      ctl_d[i] = ctl_q[i-1];
    end
    ctl_d[FLAG_STAGE].ss_hit = (dist2_q < {3'b0, r2s3_q});
    ctl_d[FLAG_STAGE].dd_nz  = |dd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) begin
        ctl_q[i] <= '0;
      end
      hit_q <= 1'b0;
    end else begin
      for (int i = 0; i < LAT; i++) begin
        ctl_q[i] <= ctl_d[i];
      end
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      w_q[i]     <= w_d[i];
      d_q[i]     <= d_d[i];
      sqd_q[i]   <= sqd_d[i];
      sqw_q[i]   <= sqw_d[i];
      cross_q[i] <= cross_d[i];
    end
    for (int i = 0; i < 6; i++) begin
      pwd_q[i] <= pwd_d[i];
    end
    rsum_q  <= rsum_d;
    r2s2_q  <= r2s2_d;
    r2s3_q  <= r2s2_q;
    dd_q    <= dd_d;
    dist2_q <= dist2_d;
    lhs_q   <= lhs_d;
    rhs6_q  <= rhs6_d;
  end

  assign done_o = ctl_q[LAT-1].vld;
  assign hit_o  = hit_q;

  // ---- checks
  `CPOT_ASSERT_IMPL(a_done_from_start, clk_i, rst_ni, done_o, $past(start_i && !busy_o, LAT))
  `CPOT_ASSERT_IMPL(a_hit_only_done, clk_i, rst_ni, hit_o, done_o)
  `CPOT_ASSERT_IMPL(a_hit_needs_test, clk_i, rst_ni, hit_o, ($past(action_i, LAT) == ACT_SPHERE) || ($past(action_i, LAT) == ACT_LINE))

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collider pair overlap test - testbench
// Drives sphere-sphere, line-sphere and unsupported pairs through the
// start/busy command port. Each pair is scored against an exact wide-integer
// model of the overlap test, and each done_o strobe is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  import cpot_pkg::*;

  localparam int CB    = 24;
  localparam int ONE   = 256;                  // 1.0 in Q16.8
  localparam int CMIN  = -(2 ** (CB - 1));
  localparam int CMAX  = 2 ** (CB - 1) - 1;
  localparam int RMAX  = 2 ** (CB - 1) - 1;

  // codes that do no test; the block only names the two real pair kinds
  localparam logic [1:0] ACT_UNSUPPORTED = 2'd2;
  localparam logic [1:0] ACT_RESERVED    = 2'd3;

  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic [1:0]           action;
    logic signed [CB-1:0] first_x, first_y, first_z;
    logic signed [CB-1:0] end_x, end_y, end_z;
    logic signed [CB-1:0] sphere_x, sphere_y, sphere_z;
    logic [CB-2:0]        first_radius, sphere_radius;
  } pair_t;

  typedef struct {
    logic        hit;
    int unsigned tag;
    logic [1:0]  action;
  } hit_entry_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [1:0]           action_i = '0;
  logic signed [CB-1:0] first_x_i = '0, first_y_i = '0, first_z_i = '0;
  logic signed [CB-1:0] line_end_x_i = '0, line_end_y_i = '0, line_end_z_i = '0;
  logic signed [CB-1:0] sphere_x_i = '0, sphere_y_i = '0, sphere_z_i = '0;
  logic [CB-2:0]        first_radius_i = '0, sphere_radius_i = '0;
  logic                 done_o;
  logic                 hit_o;

  hit_entry_t  hit_expect_q[$];
  hit_entry_t  head;
  int unsigned pairs_sent;
  int unsigned sent_by_action[4];
  int unsigned hits_seen, misses_seen;
  int unsigned fail_count;
  bit          back_to_back;

  collider_pair_overlap_test #(.COORD_BITS(CB)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .action_i        (action_i),
    .first_x_i       (first_x_i),
    .first_y_i       (first_y_i),
    .first_z_i       (first_z_i),
    .line_end_x_i    (line_end_x_i),
    .line_end_y_i    (line_end_y_i),
    .line_end_z_i    (line_end_z_i),
    .sphere_x_i      (sphere_x_i),
    .sphere_y_i      (sphere_y_i),
    .sphere_z_i      (sphere_z_i),
    .first_radius_i  (first_radius_i),
    .sphere_radius_i (sphere_radius_i),
    .done_o          (done_o),
    .hit_o           (hit_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] ERROR: %s", $time, msg);
  endfunction

  // exact overlap decision; widths are far above the worst-case products
  function automatic logic predict_hit(pair_t p);
    wide_t f[3], e[3], s[3], w[3], d[3];
    wide_t ra, rb, r2, dd, cx, cy, cz, lhs;
    logic  hit;
    int    i;
    f[0] = wide_t'(p.first_x);
    f[1] = wide_t'(p.first_y);
    f[2] = wide_t'(p.first_z);
    e[0] = wide_t'(p.end_x);
    e[1] = wide_t'(p.end_y);
    e[2] = wide_t'(p.end_z);
    s[0] = wide_t'(p.sphere_x);
    s[1] = wide_t'(p.sphere_y);
    s[2] = wide_t'(p.sphere_z);
    ra = wide_t'(p.first_radius);
    rb = wide_t'(p.sphere_radius);
    r2 = (ra + rb) * (ra + rb);
    for (i = 0; i < 3; i++) begin
      w[i] = s[i] - f[i];
      d[i] = e[i] - f[i];
    end
    hit = 1'b0;
    case (p.action)
      ACT_SPHERE: begin
        hit = (w[0] * w[0] + w[1] * w[1] + w[2] * w[2]) < r2;
      end
      ACT_LINE: begin
        dd = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        if (dd != 0) begin
          cx  = w[1] * d[2] - w[2] * d[1];
          cy  = w[2] * d[0] - w[0] * d[2];
          cz  = w[0] * d[1] - w[1] * d[0];
          lhs = cx * cx + cy * cy + cz * cz;
          hit = lhs <= r2 * dd;
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    return hit;
  endfunction

  function automatic pair_t make_pair(logic [1:0] act, int fx, int fy, int fz,
                                      int ex, int ey, int ez, int sx, int sy, int sz,
                                      int fr, int sr);
    pair_t p;
    p.action = act;
    p.first_x = CB'(fx);  p.first_y = CB'(fy);  p.first_z = CB'(fz);
    p.end_x = CB'(ex);    p.end_y = CB'(ey);    p.end_z = CB'(ez);
    p.sphere_x = CB'(sx); p.sphere_y = CB'(sy); p.sphere_z = CB'(sz);
    p.first_radius = (CB-1)'(fr);
    p.sphere_radius = (CB-1)'(sr);
    return p;
  endfunction

  function automatic int rand_offset(int k);
    return int'($urandom_range(0, 2 ** (k + 1))) - 2 ** k;
  endfunction

  // mix of full-range noise, clustered geometry and exact axis-aligned touches
  function automatic pair_t random_pair();
    pair_t       p;
    int unsigned sel, style;
    int          k, a, b, r1, r2, off;
    int          st[3], en[3], sp[3];
    sel = $urandom_range(0, 99);
    if (sel < 10) p.action = ($urandom_range(0, 1) != 0) ? ACT_UNSUPPORTED : ACT_RESERVED;
    else if (sel < 55) p.action = ACT_SPHERE;
    else p.action = ACT_LINE;
    style = $urandom_range(0, 9);
    k = $urandom_range(1, 20);
    for (int i = 0; i < 3; i++) begin
      st[i] = int'($urandom_range(0, 2 ** 23 - 1)) - 2 ** 22;
      en[i] = st[i] + rand_offset(k);
      sp[i] = st[i] + rand_offset(k);
    end
    r1 = $urandom_range(0, 2 ** k);
    r2 = $urandom_range(0, 2 ** k);
    if (style < 3) begin
      for (int i = 0; i < 3; i++) begin
        st[i] = $urandom;
        en[i] = $urandom;
        sp[i] = $urandom;
      end
      r1 = $urandom;
      r2 = $urandom;
    end else if (style >= 8) begin
      a = $urandom_range(0, 2);
      b = (a + 1 + $urandom_range(0, 1)) % 3;
      off = ($urandom_range(0, 1) != 0) ? r1 + r2 : -(r1 + r2);
      for (int i = 0; i < 3; i++) sp[i] = st[i];
      if (p.action == ACT_LINE) begin
        en = st;
        en[a] = st[a] + (($urandom_range(0, 1) != 0) ? 1 : -1) * $urandom_range(1, 2 ** k);
        sp[a] = st[a] + rand_offset(k);
        sp[b] = st[b] + off;
      end else begin
        sp[a] = st[a] + off;
      end
    end
    if (p.action == ACT_LINE && $urandom_range(0, 19) == 0) en = st;
    if (p.action != ACT_LINE) begin
      for (int i = 0; i < 3; i++) en[i] = $urandom;
    end
    p = make_pair(p.action, st[0], st[1], st[2], en[0], en[1], en[2],
                  sp[0], sp[1], sp[2], r1, r2);
    return p;
  endfunction

  task automatic send_pair(input pair_t p);
    int unsigned gap;
    gap = back_to_back ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    action_i        <= p.action;
    first_x_i       <= p.first_x;
    first_y_i       <= p.first_y;
    first_z_i       <= p.first_z;
    line_end_x_i    <= p.end_x;
    line_end_y_i    <= p.end_y;
    line_end_z_i    <= p.end_z;
    sphere_x_i      <= p.sphere_x;
    sphere_y_i      <= p.sphere_y;
    sphere_z_i      <= p.sphere_z;
    first_radius_i  <= p.first_radius;
    sphere_radius_i <= p.sphere_radius;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    hit_expect_q.push_back('{hit: predict_hit(p), tag: pairs_sent, action: p.action});
    pairs_sent++;
    sent_by_action[p.action]++;
  endtask

  // sender holds off until every outstanding transaction has come back
  task automatic wait_for_results();
    start_i <= 1'b0;
    while (hit_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_unsupported_actions();
    send_pair(make_pair(ACT_UNSUPPORTED, 0, 0, 0, 0, 0, 0, 0, 0, 0, ONE, ONE));
    send_pair(make_pair(ACT_RESERVED, 0, 0, 0, ONE, 0, 0, 0, 0, 0, ONE, ONE));
  endtask

  task automatic test_sphere_sphere_cases();
    // touching is a miss, one lsb closer is a hit
    send_pair(make_pair(ACT_SPHERE, 0, 0, 0, 0, 0, 0, 3 * ONE, 0, 0, ONE, 2 * ONE));
    send_pair(make_pair(ACT_SPHERE, 0, 0, 0, 0, 0, 0, 3 * ONE - 1, 0, 0, ONE, 2 * ONE));
    send_pair(make_pair(ACT_SPHERE, -3 * ONE, -4 * ONE, 0, 0, 0, 0, 0, 0, 0,
                        2 * ONE, 3 * ONE));
    send_pair(make_pair(ACT_SPHERE, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE, 0, 0));
    send_pair(make_pair(ACT_SPHERE, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE, 1, 0));
    send_pair(make_pair(ACT_SPHERE, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                        CMAX, CMAX, CMAX, RMAX, RMAX));
    send_pair(make_pair(ACT_SPHERE, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                        CMIN + 1, CMIN + 1, CMIN, RMAX, RMAX));
  endtask

  task automatic test_line_sphere_cases();
    // zero-length line never hits
    send_pair(make_pair(ACT_LINE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE,
                        RMAX, RMAX));
    // touching line is a hit, one lsb further is a miss
    send_pair(make_pair(ACT_LINE, 0, 0, 0, ONE, 0, 0, 5 * ONE, 2 * ONE, 0, ONE, ONE));
    send_pair(make_pair(ACT_LINE, 0, 0, 0, ONE, 0, 0, 5 * ONE, 2 * ONE + 1, 0, ONE, ONE));
    // line is infinite: sphere far past the end point still hits
    send_pair(make_pair(ACT_LINE, 0, 0, 0, ONE, 0, 0, 1000 * ONE, 0, 0, 0, 0));
    send_pair(make_pair(ACT_LINE, 0, 0, 0, 0, 0, -7, 3 * ONE, 4 * ONE, 100, 5 * ONE, 0));
    send_pair(make_pair(ACT_LINE, 0, 0, 0, 0, 0, -7, 3 * ONE, 4 * ONE, 100,
                        5 * ONE - 1, 0));
    send_pair(make_pair(ACT_LINE, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                        CMAX, CMIN, CMAX, 0, 0));
    send_pair(make_pair(ACT_LINE, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX,
                        CMAX, CMIN, CMAX, RMAX, RMAX));
    send_pair(make_pair(ACT_LINE, CMAX, CMAX, CMAX, CMAX - 1, CMAX, CMAX,
                        0, CMAX, CMAX, 0, 0));
    send_pair(make_pair(ACT_LINE, CMIN, CMAX, 0, CMAX, CMIN, 0, 0, 0, CMIN, RMAX, 0));
  endtask

  task automatic test_random_pairs(input int count, input bit no_gaps);
    back_to_back = no_gaps;
    repeat (count) send_pair(random_pair());
    back_to_back = 1'b0;
  endtask

  // results are strobed for one cycle; sample the pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) begin
      if (hit_expect_q.size() == 0) begin
        log_failure($sformatf("result with nothing outstanding: hit_o=%b", hit_o));
      end else begin
        head = hit_expect_q.pop_front();
        if (hit_o !== head.hit)
          log_failure($sformatf("pair %0d action %0d: expected hit=%b, got hit=%b",
                                head.tag, head.action, head.hit, hit_o));
        if (head.hit) hits_seen++;
        else misses_seen++;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unsupported_actions();
    test_sphere_sphere_cases();
    test_line_sphere_cases();
    wait_for_results();
    test_random_pairs(300, 1'b0);
    test_random_pairs(150, 1'b1);
    wait_for_results();
    test_random_pairs(250, 1'b0);
    wait_for_results();
    repeat (LAT + 4) @(posedge clk_i);
    if (hit_expect_q.size() != 0)
      log_failure($sformatf("%0d results never arrived", hit_expect_q.size()));
    $display("Checked %0d pairs: %0d sphere-sphere, %0d line-sphere, %0d with no test.",
             pairs_sent, sent_by_action[ACT_SPHERE], sent_by_action[ACT_LINE],
             sent_by_action[ACT_UNSUPPORTED] + sent_by_action[ACT_RESERVED]);
    $display("Results seen: %0d hits, %0d misses; %0d failures.",
             hits_seen, misses_seen, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
